>>> rtl/bb_pkg.sv
// Shared types, constants and helper functions of the 3x3 box blur.
`timescale 1ns / 1ps
`default_nettype none
package bb_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int HEIGHT_LIMIT  = 4096;
	localparam int FW_RESET      = 640;
	localparam int FH_RESET      = 480;
	localparam int RECIP_SHIFT   = 20;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	// Work packet passed from front to back.
	typedef struct packed {
		logic        wr;
		logic [1:0]  wr_slot;
		logic [11:0] wr_col;
		logic [23:0] pix;
		logic        e0;
		logic        e1;
		logic [11:0] cc0;
		logic [11:0] rr;
		logic        fe;
	} cmd_t;

	// x mod 3; 4 = 1 (mod 3), so the 2-bit digits just add up.
	function automatic logic [1:0] mod3(input logic [11:0] x);
		logic [4:0] s;
		s = 5'(x[1:0]) + 5'(x[3:2]) + 5'(x[5:4]) + 5'(x[7:6]) + 5'(x[9:8]) + 5'(x[11:10]);
		case (s)
			5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18: mod3 = 2'd0;
			5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16:       mod3 = 2'd1;
			default:                                     mod3 = 2'd2;
		endcase
	endfunction

	// ceil(2^20 / (2*cnt)) for cnt 1..9.
	function automatic logic [19:0] recip(input logic [3:0] cnt);
		case (cnt)
			4'd1:    recip = 20'd524288;
			4'd2:    recip = 20'd262144;
			4'd3:    recip = 20'd174763;
			4'd4:    recip = 20'd131072;
			4'd5:    recip = 20'd104858;
			4'd6:    recip = 20'd87382;
			4'd7:    recip = 20'd74899;
			4'd8:    recip = 20'd65536;
			4'd9:    recip = 20'd58255;
			default: recip = 20'd524288;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> rtl/box_blur_3x3.sv
// Top level of the 3x3 edge-normalised box blur.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  pix     | pix_valid/pix_stall | func, red, green, blue
//  res     | res_valid/res_stall | out_red/green/blue, out_row, out_col,
//          |                     | frame_end
//  cfg     | cfg_valid/cfg_ready | cfg_index (0 width, 1 height), cfg_data
//
// A beat passes through a pick-up and a store write in the back end, and then
// each result takes a scan of the nine neighbour positions through the single
// read port of the row store, a flush, the reciprocal multiply and the hand-off
// to the result register, which waits while the result register is stalled.
// The front accepts beats into a four-deep command queue; pix_stall rises
// only when that queue is full. Reset clears position counters, queue and
// control; the row store has no reset and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_3x3 import bb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pix_valid,
	output logic             pix_stall,
	input  wire logic        func,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic [11:0]      out_row,
	output logic [9:0]       out_col,
	output logic             frame_end,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data
);
	logic [10:0] fw_q;
	logic [12:0] fh_q;
	logic [12:0] eff_w, eff_h;
	logic        q_full, q_empty, q_pop, take;
	cmd_t        f_cmd, q_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 11'(FW_RESET);
			fh_q <= 13'(FH_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:  fw_q <= cfg_data[10:0];
				CFG_HEIGHT: fh_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Zero means one; oversize saturates.
	always_comb begin
		eff_w = 13'(fw_q);
		if (fw_q == 11'd0)
			eff_w = 13'd1;
		else if (13'(fw_q) > 13'(MAX_WIDTH))
			eff_w = 13'(MAX_WIDTH);
		eff_h = fh_q;
		if (fh_q == 13'd0)
			eff_h = 13'd1;
		else if (fh_q > 13'(HEIGHT_LIMIT))
			eff_h = 13'(HEIGHT_LIMIT);
	end

	assign pix_stall = q_full;
	assign take      = pix_valid && !q_full;

	bb_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.eff_w (eff_w),
		.eff_h (eff_h),
		.take  (take),
		.func  (func),
		.pix   ({red, green, blue}),
		.cmd   (f_cmd)
	);

	bb_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take),
		.wdata (f_cmd),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_cmd),
		.empty (q_empty)
	);

	bb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.q_empty  (q_empty),
		.q_data   (q_cmd),
		.q_pop    (q_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_red  (out_red),
		.out_green(out_green),
		.out_blue (out_blue),
		.out_row  (out_row),
		.out_col  (out_col),
		.frame_end(frame_end)
	);
endmodule
`default_nettype wire

>>> rtl/bb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 3072
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/bb_queue.sv
// Small command FIFO between front and back.
`timescale 1ns / 1ps
`default_nettype none
module bb_queue import bb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      empty
);
	cmd_t       buf_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full  = cnt_q == 3'd4;
	assign empty = cnt_q == 3'd0;
	assign rdata = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 2'd1;
			if (pop)
				rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule
`default_nettype wire

>>> rtl/bb_front.sv
// Front end: tracks raster position and turns each beat into a command.
`timescale 1ns / 1ps
`default_nettype none
module bb_front import bb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [12:0] eff_w,
	input  wire logic [12:0] eff_h,
	input  wire logic        take,
	input  wire logic        func,
	input  wire logic [23:0] pix,
	output cmd_t             cmd
);
	logic [11:0] row_q;
	logic [11:0] col_q;
	logic [12:0] drain_q;
	logic [12:0] col, row, dcol;
	logic        row_end, last;

	always_comb begin
		col = 13'(col_q);
		row = 13'(row_q);
		if (13'(col_q) >= eff_w) begin
			col = '0;
			row = 13'(row_q) + 13'd1;
		end
		if (row >= eff_h)
			row = '0;
		row_end = col == eff_w - 13'd1;
		dcol    = (drain_q >= eff_w) ? 13'd0 : drain_q;
		last    = dcol == eff_w - 13'd1;

		cmd = '0;
		if (func == FUNC_DRAIN) begin
			cmd.e0  = 1'b1;
			cmd.cc0 = dcol[11:0];
			cmd.rr  = 12'(eff_h - 13'd1);
			cmd.fe  = last;
		end else begin
			cmd.wr      = 1'b1;
			cmd.wr_slot = mod3(row[11:0]);
			cmd.wr_col  = col[11:0];
			cmd.pix     = pix;
			cmd.e0      = (row != 13'd0) && (col != 13'd0);
			cmd.e1      = (row != 13'd0) && row_end;
			cmd.cc0     = 12'(col - 13'd1);
			cmd.rr      = 12'(row - 13'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			drain_q <= '0;
		end else if (take) begin
			if (func == FUNC_DRAIN) begin
				drain_q <= last ? 13'd0 : dcol + 13'd1;
			end else if (row_end) begin
				col_q <= '0;
				if (row == eff_h - 13'd1) begin
					row_q   <= '0;
					drain_q <= '0;
				end else begin
					row_q <= 12'(row + 13'd1);
				end
			end else begin
				col_q <= 12'(col + 13'd1);
				row_q <= row[11:0];
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/bb_back.sv
// Back end: store writes, 3x3 neighbourhood scan, divide and result register.
`timescale 1ns / 1ps
`default_nettype none
module bb_back import bb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [12:0] eff_w,
	input  wire logic [12:0] eff_h,
	input  wire logic        q_empty,
	input  wire cmd_t        q_data,
	output logic             q_pop,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic [11:0]      out_row,
	output logic [9:0]       out_col,
	output logic             frame_end
);
	localparam int DEPTH = 3 * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_WRITE, S_SCAN, S_FLUSH, S_DIV, S_OUT} state_t;

	state_t      state_q;
	cmd_t        cmd_q;
	logic [11:0] cc_q;
	logic [1:0]  dr_q, dc_q;
	logic [11:0] sr_q, sg_q, sb_q;
	logic [3:0]  cnt_q;
	logic        rd_valid_s1;
	logic [32:0] pr_q, pg_q, pb_q;
	logic        out_valid_q;
	logic        e1_done_q;

	logic          r_ok, c_ok, rd_en, out_free;
	logic [1:0]    slot, base;
	logic [12:0]   col;
	logic [AW-1:0] raddr, waddr;
	logic [23:0]   rdata;
	logic [19:0]   rc;

	always_comb begin
		base = mod3(cmd_q.rr);
		case (dr_q)
			2'd0:    slot = (base == 2'd0) ? 2'd2 : base - 2'd1;
			2'd2:    slot = (base == 2'd2) ? 2'd0 : base + 2'd1;
			default: slot = base;
		endcase
		r_ok = !((dr_q == 2'd0) && (cmd_q.rr == 12'd0)) &&
		       !((dr_q == 2'd2) && ((13'(cmd_q.rr) + 13'd1) >= eff_h));
		c_ok = !((dc_q == 2'd0) && (cc_q == 12'd0)) &&
		       !((dc_q == 2'd2) && ((13'(cc_q) + 13'd1) >= eff_w));
		col   = 13'(cc_q) + 13'(dc_q) - 13'd1;
		rd_en = (state_q == S_SCAN) && r_ok && c_ok;
		raddr = AW'(slot) * AW'(MAX_WIDTH) + AW'(col);
		waddr = AW'(cmd_q.wr_slot) * AW'(MAX_WIDTH) + AW'(cmd_q.wr_col);
		rc    = recip(cnt_q);
	end

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;

	bb_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store (
		.clk  (clk),
		.we   (state_q == S_WRITE && cmd_q.wr),
		.waddr(waddr),
		.wdata(cmd_q.pix),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && !q_empty)
			cmd_q <= q_data;
		if (state_q == S_WRITE || state_q == S_OUT) begin
			sr_q  <= '0;
			sg_q  <= '0;
			sb_q  <= '0;
			cnt_q <= '0;
		end else if (rd_valid_s1) begin
			sr_q  <= sr_q + 12'(rdata[23:16]);
			sg_q  <= sg_q + 12'(rdata[15:8]);
			sb_q  <= sb_q + 12'(rdata[7:0]);
			cnt_q <= cnt_q + 4'd1;
		end
		if (state_q == S_DIV) begin
			pr_q <= 33'({sr_q, 1'b0} + 13'(cnt_q)) * 33'(rc);
			pg_q <= 33'({sg_q, 1'b0} + 13'(cnt_q)) * 33'(rc);
			pb_q <= 33'({sb_q, 1'b0} + 13'(cnt_q)) * 33'(rc);
		end
		if (state_q == S_OUT && out_free) begin
			out_red   <= pr_q[RECIP_SHIFT +: 8];
			out_green <= pg_q[RECIP_SHIFT +: 8];
			out_blue  <= pb_q[RECIP_SHIFT +: 8];
			out_row   <= cmd_q.rr;
			out_col   <= cc_q[9:0];
			frame_end <= cmd_q.fe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cc_q        <= '0;
			dr_q        <= '0;
			dc_q        <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			out_valid_q <= (out_valid_q && res_stall) || (state_q == S_OUT && out_free);
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty)
						state_q <= S_WRITE;
				end
				S_WRITE, S_OUT: begin
					if (state_q == S_WRITE || out_free) begin
						dr_q <= '0;
						dc_q <= '0;
						if (state_q == S_WRITE && cmd_q.e0) begin
							cc_q    <= cmd_q.cc0;
							state_q <= S_SCAN;
						end else if (cmd_q.e1 && !e1_done_q) begin
							// last-column emit of a row-end beat, after the e0 emit if there is one
							cc_q    <= 12'(eff_w - 13'd1);
							state_q <= S_SCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SCAN: begin
					if (dc_q == 2'd2) begin
						dc_q <= '0;
						if (dr_q == 2'd2)
							state_q <= S_FLUSH;
						else
							dr_q <= dr_q + 2'd1;
					end else begin
						dc_q <= dc_q + 2'd1;
					end
				end
				S_FLUSH: state_q <= S_DIV;
				S_DIV:   state_q <= S_OUT;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Last-column emit of a row-end beat has started; cleared on the next pick-up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			e1_done_q <= 1'b0;
		else if (state_q == S_IDLE)
			e1_done_q <= 1'b0;
		else if ((state_q == S_WRITE || (state_q == S_OUT && out_free)) &&
		         !(state_q == S_WRITE && cmd_q.e0) && cmd_q.e1 && !e1_done_q)
			e1_done_q <= 1'b1;
	end
endmodule
`default_nettype wire
